// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the queue and back-end RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication check
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/afce_pkg.sv =====
// Types, character constants and hex helper for the ASCII frame checksum encoder.
package afce_pkg;

  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [3:0] NIB_TEN    = 4'd10;

  // Register index of the letter-case setting
  localparam logic REG_HEX_UPPER = 1'b0;

  // One classified payload byte waiting for the back end
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] lrc;
    logic       upper;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  // Map a nibble to its ASCII hex digit
  function automatic logic [7:0] nib_char(logic [3:0] nib, logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (nib < NIB_TEN) begin
      return CH_ZERO + {4'b0, nib};
    end
    return base + {4'b0, nib - NIB_TEN};
  endfunction

endpackage

// ===== hw/rtl/ascii_frame_checksum_encoder_top.sv =====
// ASCII frame checksum encoder, top level.
// Takes payload bytes with a last-byte flag and sends a framed ASCII stream:
// a colon before a message, each payload byte unchanged, then the two's
// complement of the modulo-256 byte sum as two hex digits (high nibble first)
// and a newline. The output port sends one character per cycle unless out_tready
// stalls it; the first byte of a message also brings the colon and the last byte
// the two hex digits and the newline. The input side keeps taking one byte per
// cycle while the queue (QUEUE_DEPTH entries) has room, and stalls when a burst of
// checksum characters backs it up. Register 0 (address 0x0, bit 0, reset 1)
// selects upper-case hex letters; it is sampled per byte, so the setting in
// force when the last byte is taken decides the checksum's letter case.
module ascii_frame_checksum_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast,  // frame_end
  output logic [0:0]  out_tuser,  // [0] burst_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import afce_pkg::*;

  logic     hex_upper_r, hex_upper_nxt;
  logic     cfg_wr;
  logic     q_full, q_valid, pop;
  q_push_t  push;
  q_entry_t head;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    hex_upper_nxt = hex_upper_r;
    if (cfg_wr && (cfg_paddr[2] == REG_HEX_UPPER)) begin
      hex_upper_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_upper_r <= 1'b1;
    end else begin
      hex_upper_r <= hex_upper_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEX_UPPER) ? {31'b0, hex_upper_r} : 32'b0;

  afce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .hex_upper (hex_upper_r),
    .q_full    (q_full),
    .push      (push)
  );

  afce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop)
  );

  afce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/afce_front.sv =====
// Front end: accepts payload bytes, tracks frame state and the running sum.
module afce_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] payload_byte
  input  logic             in_tlast,   // last_byte
  input  logic             hex_upper,
  input  logic             q_full,
  output afce_pkg::q_push_t push
);
  import afce_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_add;
  logic       xfer;

  assign in_tready = !q_full;
  assign xfer      = in_tvalid && in_tready;
  assign sum_add   = sum_r + in_tdata;

  // Classify the byte and form the checksum on the fly
  always_comb begin
    push.valid       = xfer;
    push.entry.data  = in_tdata;
    push.entry.first = !in_frame_r;
    push.entry.last  = in_tlast;
    push.entry.lrc   = 8'd0 - sum_add;
    push.entry.upper = hex_upper;
  end

  // Advance frame state on each transfer
  always_comb begin
    in_frame_nxt = in_frame_r;
    sum_nxt      = sum_r;
    if (xfer) begin
      in_frame_nxt = !in_tlast;
      sum_nxt      = in_tlast ? 8'd0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      sum_r      <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      sum_r      <= sum_nxt;
    end
  end

endmodule

// ===== hw/rtl/afce_queue.sv =====
// Short queue between front and back end.
`include "assert_macros.svh"
module afce_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  afce_pkg::q_push_t  push,
  output logic               full,
  output logic               q_valid,
  output afce_pkg::q_entry_t head,
  input  logic               pop
);
  import afce_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid;
  assign do_pop  = pop;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  `CHK_IMPL(a_no_push_full, clk, rst_n, do_push, !full)
  `CHK_IMPL(a_no_pop_empty, clk, rst_n, do_pop, q_valid)
  `CHK_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))

endmodule

// ===== hw/rtl/afce_back.sv =====
// Back end: expands each queued byte into its output characters.
`include "assert_macros.svh"
module afce_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  afce_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [7:0] out_char
  output logic               out_tlast,  // frame_end
  output logic [0:0]         out_tuser   // [0] burst_last
);
  import afce_pkg::*;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_BYTE  = 5'b00010,
    PH_HI    = 5'b00100,
    PH_LO    = 5'b01000,
    PH_NL    = 5'b10000
  } phase_t;

  phase_t     ph_r, ph_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_fe_r, out_bl_r;
  logic       adv;
  logic [7:0] ch;
  logic       fe, bl;

  assign adv = q_valid && (!out_valid_r || out_tready);

  // Select the character for the current phase
  always_comb begin
    ph_nxt = ph_r;
    ch     = head.data;
    fe     = 1'b0;
    bl     = 1'b0;
    pop    = 1'b0;
    case (ph_r)
      PH_START: begin
        if (head.first) begin
          ch     = CH_COLON;
          ph_nxt = PH_BYTE;
        end else begin
          ch     = head.data;
          bl     = !head.last;
          pop    = !head.last;
          ph_nxt = head.last ? PH_HI : PH_START;
        end
      end
      PH_BYTE: begin
        ch     = head.data;
        bl     = !head.last;
        pop    = !head.last;
        ph_nxt = head.last ? PH_HI : PH_START;
      end
      PH_HI: begin
        ch     = nib_char(head.lrc[7:4], head.upper);
        ph_nxt = PH_LO;
      end
      PH_LO: begin
        ch     = nib_char(head.lrc[3:0], head.upper);
        ph_nxt = PH_NL;
      end
      PH_NL: begin
        ch     = CH_NEWLINE;
        fe     = 1'b1;
        bl     = 1'b1;
        pop    = 1'b1;
        ph_nxt = PH_START;
      end
      default: begin
        ph_nxt = PH_START;
      end
    endcase
    if (!adv) begin
      ph_nxt = ph_r;
      pop    = 1'b0;
    end
  end

  // Hold the output until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char_r <= ch;
      out_fe_r   <= fe;
      out_bl_r   <= bl;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_char_r;
  assign out_tlast    = out_fe_r;
  assign out_tuser[0] = out_bl_r;

  `CHK_IMPL(a_fe_burst, clk, rst_n, out_valid_r && out_fe_r, out_bl_r)
  `CHK_IMPL(a_mid_head, clk, rst_n, ph_r != PH_START, q_valid)
  `CHK_NEXT(a_nl_ret, clk, rst_n, adv && (ph_r == PH_NL), ph_r == PH_START)

endmodule
